### src/fpsqrt_pkg.sv
// shared types, widths, seed table and leading-zero count for the square root
// no dependencies

package fpsqrt_pkg;

  localparam int RadW    = 32;
  localparam int ValW    = 31;
  localparam int XW      = 32;
  localparam int ShW     = 4;
  localparam int LzW     = 6;
  localparam int RootW   = 31;
  localparam int IdxW    = 6;
  localparam int DivSteps = 32;

  localparam logic [RootW-1:0] MaxRoot = 31'd1518500250;

  typedef struct packed {
    logic [ValW-1:0] val;
    logic [ShW-1:0]  shift_half;
    logic            zero;
  } fpsqrt_ctx_t;

  localparam logic [XW-1:0] SeedRom [64] = '{
    32'd189812531,  32'd268435456,  32'd328764948,  32'd379625062,
    32'd424433723,  32'd464943848,  32'd502196753,  32'd536870912,
    32'd569437594,  32'd600239927,  32'd629536947,  32'd657529896,
    32'd684378814,  32'd710213460,  32'd735140772,  32'd759250125,
    32'd782617115,  32'd805306368,  32'd827373642,  32'd848867446,
    32'd869830292,  32'd890299688,  32'd910308921,  32'd929887697,
    32'd949062656,  32'd967857801,  32'd986294844,  32'd1004393507,
    32'd1022171763, 32'd1039646051, 32'd1056831447, 32'd1073741824,
    32'd1090389977, 32'd1106787739, 32'd1122946079, 32'd1138875187,
    32'd1154584553, 32'd1170083026, 32'd1185378878, 32'd1200479854,
    32'd1215393219, 32'd1230125796, 32'd1244684005, 32'd1259073893,
    32'd1273301169, 32'd1287371222, 32'd1301289153, 32'd1315059792,
    32'd1328687719, 32'd1342177280, 32'd1355532607, 32'd1368757628,
    32'd1381856086, 32'd1394831545, 32'd1407687407, 32'd1420426919,
    32'd1433053185, 32'd1445569171, 32'd1457977717, 32'd1470281545,
    32'd1482483261, 32'd1494585366, 32'd1506590260, 32'd1518500250
  };

  function automatic logic [LzW-1:0] lead_zeros(input logic [RadW-1:0] v);
    logic [LzW-1:0] cnt;
    cnt = LzW'(RadW);
    for (int i = 0; i < RadW; i++) begin
      if (v[i]) begin
        cnt = LzW'(RadW - 1 - i);
      end
    end
    return cnt;
  endfunction

endpackage

### src/fpsqrt_div.sv
// pipelined restoring divider: ({val, 30 zero bits}) / x, one quotient bit per stage
// depends on fpsqrt_pkg

module fpsqrt_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [fpsqrt_pkg::XW-1:0] in_x,
  input  fpsqrt_pkg::fpsqrt_ctx_t  in_ctx,
  output logic                     res_valid,
  output logic [fpsqrt_pkg::XW-1:0] res_quo,
  output logic [fpsqrt_pkg::XW-1:0] res_x,
  output fpsqrt_pkg::fpsqrt_ctx_t  res_ctx
);

  localparam int N = fpsqrt_pkg::DivSteps;
  localparam int W = fpsqrt_pkg::XW;

  logic                    st_valid [1:N];
  logic [W-1:0]            st_rem   [1:N];
  logic [W-1:0]            st_quo   [1:N];
  logic [W-1:0]            st_div   [1:N];
  fpsqrt_pkg::fpsqrt_ctx_t st_ctx   [1:N];

  for (genvar i = 0; i < N; i++) begin : g_step
    logic                    cur_valid;
    logic [W-1:0]            cur_rem;
    logic [W-1:0]            cur_quo;
    logic [W-1:0]            cur_div;
    fpsqrt_pkg::fpsqrt_ctx_t cur_ctx;
    logic                    bit_in;
    logic [W:0]              trial;
    logic                    ge;
    logic [W-1:0]            rem_next;

    if (i == 0) begin : g_first
      // upper dividend bits are val[30:2], always below the divisor
      assign cur_valid = in_valid;
      assign cur_rem   = W'(in_ctx.val[fpsqrt_pkg::ValW-1:2]);
      assign cur_quo   = '0;
      assign cur_div   = in_x;
      assign cur_ctx   = in_ctx;
    end else begin : g_next
      assign cur_valid = st_valid[i];
      assign cur_rem   = st_rem[i];
      assign cur_quo   = st_quo[i];
      assign cur_div   = st_div[i];
      assign cur_ctx   = st_ctx[i];
    end

    if (i == 0) begin : g_b1
      assign bit_in = cur_ctx.val[1];
    end else if (i == 1) begin : g_b0
      assign bit_in = cur_ctx.val[0];
    end else begin : g_bz
      assign bit_in = 1'b0;
    end

    assign trial    = {cur_rem, bit_in};
    assign ge       = trial >= {1'b0, cur_div};
    assign rem_next = ge ? W'(trial - {1'b0, cur_div}) : trial[W-1:0];

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[i+1] <= 1'b0;
      end else if (en) begin
        st_valid[i+1] <= cur_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_rem[i+1] <= rem_next;
        st_quo[i+1] <= {cur_quo[W-2:0], ge};
        st_div[i+1] <= cur_div;
        st_ctx[i+1] <= cur_ctx;
      end
    end
  end

  assign res_valid = st_valid[N];
  assign res_quo   = st_quo[N];
  assign res_x     = st_div[N];
  assign res_ctx   = st_ctx[N];

endmodule

### src/fixed_point_square_root.sv
// top level of the Q2.30 square root pipeline
// depends on fpsqrt_pkg and fpsqrt_div

// Takes one Q2.30 radicand per cycle and returns its Q1.30 root; zero or negative
// inputs give zero. The pipeline is made of the two Newton steps, each a
// 32-stage restoring divider producing one quotient bit per stage, plus
// normalisation, seed lookup, the two update stages and the output register.
// Throughput is one item per clock; a waiting result in the output register
// stalls the pipeline only once the next result reaches its last stage.

module fixed_point_square_root (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [fpsqrt_pkg::RadW-1:0] radicand,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fpsqrt_pkg::RootW-1:0]      root
);

  localparam int XW = fpsqrt_pkg::XW;

  logic en;

  // normalisation count
  logic                          s1_valid;
  logic [fpsqrt_pkg::RadW-1:0]   s1_raw;
  logic [fpsqrt_pkg::ShW-1:0]    s1_sh;
  logic                          s1_zero;
  logic [fpsqrt_pkg::LzW-1:0]    lz;

  // normalised value
  logic                          s2_valid;
  fpsqrt_pkg::fpsqrt_ctx_t       s2_ctx;

  // seed
  logic                          s3_valid;
  logic [XW-1:0]                 s3_x;
  fpsqrt_pkg::fpsqrt_ctx_t       s3_ctx;

  logic                          d1_valid;
  logic [XW-1:0]                 d1_quo;
  logic [XW-1:0]                 d1_x;
  fpsqrt_pkg::fpsqrt_ctx_t       d1_ctx;

  logic                          u1_valid;
  logic [XW-1:0]                 u1_x;
  fpsqrt_pkg::fpsqrt_ctx_t       u1_ctx;

  logic                          d2_valid;
  logic [XW-1:0]                 d2_quo;
  logic [XW-1:0]                 d2_x;
  fpsqrt_pkg::fpsqrt_ctx_t       d2_ctx;

  logic                          u2_valid;
  logic [XW-1:0]                 u2_x;
  fpsqrt_pkg::fpsqrt_ctx_t       u2_ctx;

  logic [XW:0]                   sum1;
  logic [XW:0]                   sum2;
  logic                          out_load;

  assign en       = !(u2_valid && out_valid && !out_ready);
  assign in_ready = en;
  assign out_load = u2_valid && (!out_valid || out_ready);

  assign lz = fpsqrt_pkg::lead_zeros(radicand);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      u1_valid <= 1'b0;
      u2_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      u1_valid <= d1_valid;
      u2_valid <= d2_valid;
    end
  end

  assign sum1 = {1'b0, d1_quo} + {1'b0, d1_x} + (XW+1)'(1);
  assign sum2 = {1'b0, d2_quo} + {1'b0, d2_x} + (XW+1)'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_raw  <= radicand;
      s1_sh   <= fpsqrt_pkg::ShW'((lz - fpsqrt_pkg::LzW'(1)) >> 1);
      s1_zero <= (radicand == '0) || radicand[fpsqrt_pkg::RadW-1];

      s2_ctx.val        <= fpsqrt_pkg::ValW'(s1_raw << {s1_sh, 1'b0});
      s2_ctx.shift_half <= s1_sh;
      s2_ctx.zero       <= s1_zero;

      s3_x   <= fpsqrt_pkg::SeedRom[s2_ctx.val[fpsqrt_pkg::ValW-1 -: fpsqrt_pkg::IdxW]];
      s3_ctx <= s2_ctx;

      u1_x   <= sum1[XW:1];
      u1_ctx <= d1_ctx;

      u2_x   <= sum2[XW:1];
      u2_ctx <= d2_ctx;
    end
  end

  fpsqrt_div u_div1 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s3_valid),
    .in_x      (s3_x),
    .in_ctx    (s3_ctx),
    .res_valid (d1_valid),
    .res_quo   (d1_quo),
    .res_x     (d1_x),
    .res_ctx   (d1_ctx)
  );

  fpsqrt_div u_div2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (u1_valid),
    .in_x      (u1_x),
    .in_ctx    (u1_ctx),
    .res_valid (d2_valid),
    .res_quo   (d2_quo),
    .res_x     (d2_x),
    .res_ctx   (d2_ctx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      root <= u2_ctx.zero ? '0 : fpsqrt_pkg::RootW'(u2_x >> u2_ctx.shift_half);
    end
  end

  // pipeline holds only behind a result that is not taken
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (u2_valid && out_valid && !out_ready))
    else $error("pipeline stalled without a waiting result");

  // a stalled last stage is delivered on the next cycle the output frees up
  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    (u2_valid && !en) |=> u2_valid)
    else $error("result lost in last stage during stall");

  // first newton estimate never zero, so the second divider has a valid divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (u1_valid && !u1_ctx.zero) |-> (u1_x != '0))
    else $error("zero divisor reached second divider");

  a_root_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (root <= fpsqrt_pkg::MaxRoot))
    else $error("root above largest possible value");

endmodule

### sim/tb_fixed_point_square_root.sv
`timescale 1ns / 1ps
// testbench for fixed_point_square_root: directed and random radicands, checked
// against a local bit-exact square root predictor; depends on fpsqrt_pkg and the rtl

module tb_fixed_point_square_root;

  localparam int HalfPeriod = 6;
  localparam int DrainCycles = 100;
  localparam int LimitCycles = 200000;

  localparam logic [31:0] RootSeeds [64] = '{
    32'd189812531,  32'd268435456,  32'd328764948,  32'd379625062,
    32'd424433723,  32'd464943848,  32'd502196753,  32'd536870912,
    32'd569437594,  32'd600239927,  32'd629536947,  32'd657529896,
    32'd684378814,  32'd710213460,  32'd735140772,  32'd759250125,
    32'd782617115,  32'd805306368,  32'd827373642,  32'd848867446,
    32'd869830292,  32'd890299688,  32'd910308921,  32'd929887697,
    32'd949062656,  32'd967857801,  32'd986294844,  32'd1004393507,
    32'd1022171763, 32'd1039646051, 32'd1056831447, 32'd1073741824,
    32'd1090389977, 32'd1106787739, 32'd1122946079, 32'd1138875187,
    32'd1154584553, 32'd1170083026, 32'd1185378878, 32'd1200479854,
    32'd1215393219, 32'd1230125796, 32'd1244684005, 32'd1259073893,
    32'd1273301169, 32'd1287371222, 32'd1301289153, 32'd1315059792,
    32'd1328687719, 32'd1342177280, 32'd1355532607, 32'd1368757628,
    32'd1381856086, 32'd1394831545, 32'd1407687407, 32'd1420426919,
    32'd1433053185, 32'd1445569171, 32'd1457977717, 32'd1470281545,
    32'd1482483261, 32'd1494585366, 32'd1506590260, 32'd1518500250
  };

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic signed [fpsqrt_pkg::RadW-1:0] radicand = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic [fpsqrt_pkg::RootW-1:0]       root;

  logic [fpsqrt_pkg::RootW-1:0] expected_roots [$];
  logic [fpsqrt_pkg::RootW-1:0] wanted_root;
  int                           errors = 0;
  int                           gap_pct = 0;
  int                           stall_pct = 0;
  int                           stall_left = 0;

  fixed_point_square_root u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .radicand  (radicand),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .root      (root)
  );

  always #HalfPeriod clk = ~clk;

  function automatic logic [fpsqrt_pkg::RootW-1:0] predict_root(
    input logic [fpsqrt_pkg::RadW-1:0] raw
  );
    logic [5:0]  zeros;
    logic [4:0]  norm_shift;
    logic [30:0] norm_val;
    logic [63:0] scaled;
    logic [63:0] quot;
    logic [31:0] x;
    if (raw == '0 || raw[31]) begin
      return '0;
    end
    zeros = 6'd0;
    while (!raw[31 - zeros]) begin
      zeros++;
    end
    norm_shift = 5'(zeros - 6'd1);
    norm_shift[0] = 1'b0;
    norm_val = 31'(raw << norm_shift);
    scaled = 64'(norm_val) << 30;
    x = RootSeeds[norm_val[30:25]];
    repeat (2) begin
      quot = (x != '0) ? scaled / 64'(x) : 64'd0;
      x = 32'((quot + 64'(x) + 64'd1) >> 1);
    end
    return fpsqrt_pkg::RootW'(x >> norm_shift[4:1]);
  endfunction

  function automatic logic [fpsqrt_pkg::RadW-1:0] random_radicand();
    int pick;
    logic [fpsqrt_pkg::RadW-1:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      v = '0;
    end else if (pick < 18) begin
      v = $urandom() | 32'h8000_0000;
    end else begin
      // spread over every normalisation shift
      v = $urandom() >> $urandom_range(1, 31);
      if (v == '0) begin
        v = 32'd1;
      end
    end
    return v;
  endfunction

  // valid stays high between back-to-back transfers
  task automatic send_radicand(input logic [fpsqrt_pkg::RadW-1:0] v);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    radicand <= v;
    do @(posedge clk); while (!in_ready);
    expected_roots.push_back(predict_root(v));
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_roots.size() == 0) begin
        $display("%0t: unexpected transfer, root %0d", $time, root);
        errors++;
      end else begin
        wanted_root = expected_roots.pop_front();
        if (root !== wanted_root) begin
          $display("%0t: root mismatch, expected %0d actual %0d", $time, wanted_root, root);
          errors++;
        end
      end
    end
  end

  task automatic test_non_positive();
    gap_pct = 20;
    stall_pct = 20;
    send_radicand(32'h0000_0000);
    send_radicand(32'hffff_ffff);
    send_radicand(32'h8000_0000);
    send_radicand(32'h8000_0001);
    send_radicand(32'hc000_0000);
  endtask

  task automatic test_range_extremes();
    send_radicand(32'h7fff_ffff);
    send_radicand(32'h0000_0001);
    send_radicand(32'h0000_0002);
    send_radicand(32'h0000_0003);
    send_radicand(32'h4000_0000);
    send_radicand(32'h3fff_ffff);
    send_radicand(32'h0000_8000);
    send_radicand(32'h0001_0000);
    send_radicand(32'h5555_5555);
    send_radicand(32'h2aaa_aaaa);
  endtask

  // lowest and highest seed entries for both normalised bit positions
  task automatic test_seed_edges();
    send_radicand(32'h2000_0000);
    send_radicand(32'h7e00_0000);
    send_radicand(32'h1000_0000);
    send_radicand(32'h0800_0001);
    send_radicand(32'h0000_0fff);
  endtask

  task automatic test_random_with_idling();
    int pcts [4] = '{0, 10, 30, 60};
    for (int seg = 0; seg < 14; seg++) begin
      gap_pct = pcts[$urandom_range(0, 3)];
      stall_pct = pcts[$urandom_range(0, 3)];
      repeat (50) send_radicand(random_radicand());
    end
  endtask

  task automatic test_random_streaming();
    gap_pct = 0;
    stall_pct = 0;
    repeat (330) send_radicand(random_radicand());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_non_positive();
    test_range_extremes();
    test_seed_edges();
    test_random_with_idling();
    test_random_streaming();
    in_valid <= 1'b0;
    while (expected_roots.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0 && expected_roots.size() == 0) begin
      $display("tb_fixed_point_square_root: PASS");
    end else begin
      $display("tb_fixed_point_square_root: FAIL");
    end
    $finish;
  end

  initial begin
    #(LimitCycles * 2 * HalfPeriod);
    $display("%0t: timeout", $time);
    $display("tb_fixed_point_square_root: FAIL");
    $finish;
  end

endmodule
